[rtl/core/display_output_controller_core_assert.svh]
// Assertion macros shared by the display output controller core.
`ifndef DISPLAY_OUTPUT_CONTROLLER_CORE_ASSERT_SVH
`define DISPLAY_OUTPUT_CONTROLLER_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DOC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("display controller check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define DOC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("display controller check failed");

`endif

[rtl/core/doc_pkg.sv]
package doc_pkg;

    localparam int DigitCount = 4;

    // Command codes
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_CLEAR     = 3'd1;
    localparam logic [2:0] OP_SCAN_DIG  = 3'd2;
    localparam logic [2:0] OP_LED       = 3'd3;
    localparam logic [2:0] OP_ASCII_DIG = 3'd4;
    localparam logic [2:0] OP_DOT_A     = 3'd5;
    localparam logic [2:0] OP_DOT_ONE   = 3'd6;
    localparam logic [2:0] OP_TEXT      = 3'd7;

    // Text line actions
    localparam logic [2:0] TXT_NONE    = 3'd0;
    localparam logic [2:0] TXT_CLEARED = 3'd1;
    localparam logic [2:0] TXT_APPEND  = 3'd2;
    localparam logic [2:0] TXT_SHIFT   = 3'd3;
    localparam logic [2:0] TXT_OVERWR  = 3'd4;

    // Dot matrix choices
    localparam logic [1:0] DOT_BLANK = 2'd0;
    localparam logic [1:0] DOT_A     = 2'd1;
    localparam logic [1:0] DOT_ONE   = 2'd2;

    localparam logic [3:0] DigBlank  = 4'd10;
    localparam logic [7:0] AsciiZero = 8'd48;

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] slot;
        logic [7:0] value;
        logic       flag;
    } item_t;

    // Declared high field first so scan_select lands in the low bits
    typedef struct packed {
        logic [5:0]  text_length;
        logic [7:0]  text_char;
        logic [2:0]  text_action;
        logic        dot_write;
        logic [1:0]  dot_choice;
        logic        ascii_write;
        logic [31:0] ascii_digits;
        logic [7:0]  led_pattern;
        logic [7:0]  segment_code;
        logic [7:0]  scan_select;
    } res_t;

    // Active-low segment code, digit values above nine give 8'h00, lighting every segment
    function automatic logic [7:0] seg_code(input logic [3:0] dig);
        logic [7:0] code;
        case (dig)
            4'd0:    code = 8'h03;
            4'd1:    code = 8'h9F;
            4'd2:    code = 8'h25;
            4'd3:    code = 8'h0D;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h49;
            4'd6:    code = 8'hC1;
            4'd7:    code = 8'h1F;
            4'd8:    code = 8'h01;
            4'd9:    code = 8'h09;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // Digit enable strobe per scan position
    function automatic logic [7:0] scan_strobe(input logic [1:0] pos);
        logic [7:0] sel;
        case (pos)
            2'd0:    sel = 8'h02;
            2'd1:    sel = 8'h04;
            2'd2:    sel = 8'h10;
            default: sel = 8'h80;
        endcase
        return sel;
    endfunction

endpackage

[rtl/core/display_output_controller_core.sv]
// Display output controller core: scanned seven-segment digits, LEDs and aux strobes.
// Pipeline: an input transfer is registered in the input stage, then its result in the output stage.
// Throughput: one item per cycle unless m_tready stalls the output, set by the single command/update stage.
// Reset: synchronous active-low aresetn empties both stage registers and clears
// scan position, digits, LEDs, ASCII bytes and text line length to zero.
module display_output_controller_core #(
    parameter int LINE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // slot[1:0], value[9:2], flag[10], zero[15:11]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // scan_select[7:0], segment_code[15:8], led_pattern[23:16],
    // ascii_digits[55:24], ascii_write[56], dot_choice[58:57], dot_write[59],
    // text_action[62:60], text_char[70:63], text_length[76:71], zero[79:77]
    output logic [79:0] m_tdata
);
    import doc_pkg::*;

    `include "display_output_controller_core_assert.svh"

    logic  in_vld_reg;
    item_t in_item_reg;
    logic  out_vld_reg;
    res_t  out_res_reg;
    res_t  res_calc;
    logic  advance;
    logic  exec_en;

    // Both stages move together whenever the output slot frees up
    assign advance  = !out_vld_reg || m_tready;
    assign exec_en  = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.opcode <= s_tuser;
            in_item_reg.slot   <= s_tdata[1:0];
            in_item_reg.value  <= s_tdata[9:2];
            in_item_reg.flag   <= s_tdata[10];
        end
    end

    doc_exec #(
        .LINE_WIDTH(LINE_WIDTH)
    ) u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec_en (exec_en),
        .item    (in_item_reg),
        .res     (res_calc)
    );

    // Hold the result until the master side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_en) begin
            out_res_reg <= res_calc;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_res_reg};

    `DOC_ASSERT_NEXT(a_exec_lands, exec_en, m_tvalid)
    `DOC_ASSERT_SAME(a_scan_onehot, m_tvalid, $onehot(m_tdata[7:0]))
    `DOC_ASSERT_SAME(a_len_bound, m_tvalid, (LINE_WIDTH >= 64) || (m_tdata[76:71] <= 6'(LINE_WIDTH)))
    `DOC_ASSERT_SAME(a_shift_full, m_tvalid && (m_tdata[62:60] == TXT_SHIFT), m_tdata[76:71] == 6'(LINE_WIDTH))

endmodule

[rtl/core/doc_exec.sv]
module doc_exec #(
    parameter int LINE_WIDTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           exec_en,
    input  doc_pkg::item_t item,
    output doc_pkg::res_t  res
);
    import doc_pkg::*;

    localparam int LenW = $clog2(LINE_WIDTH + 1);

    logic [1:0]      pos_reg, pos_next;
    logic [3:0]      dig_reg   [DigitCount];
    logic [3:0]      dig_next  [DigitCount];
    logic [3:0]      led_reg, led_next;
    logic [7:0]      asc_reg   [DigitCount];
    logic [7:0]      asc_next  [DigitCount];
    logic [LenW-1:0] len_reg, len_next;

    logic       asc_wr;
    logic [1:0] dot_sel;
    logic       dot_wr;
    logic [2:0] txt_act;
    logic [7:0] txt_chr;

    // Decode the command and form the next state
    always_comb begin
        pos_next = pos_reg + 2'd1;
        dig_next = dig_reg;
        led_next = led_reg;
        asc_next = asc_reg;
        len_next = len_reg;
        asc_wr   = 1'b0;
        dot_sel  = DOT_BLANK;
        dot_wr   = 1'b0;
        txt_act  = TXT_NONE;
        txt_chr  = 8'h00;
        unique case (item.opcode)
            OP_NONE: begin
            end
            OP_CLEAR: begin
                for (int i = 0; i < DigitCount; i++) begin
                    dig_next[i] = 4'd0;
                    asc_next[i] = 8'h00;
                end
                led_next = 4'h0;
                len_next = '0;
                asc_wr   = 1'b1;
                dot_wr   = 1'b1;
                txt_act  = TXT_CLEARED;
            end
            OP_SCAN_DIG: begin
                dig_next[item.slot] = (item.value > 8'(DigBlank)) ? DigBlank
                                                                  : item.value[3:0];
            end
            OP_LED: begin
                led_next[item.slot] = item.flag;
            end
            OP_ASCII_DIG: begin
                asc_next[item.slot] = item.value + AsciiZero;
                asc_wr              = 1'b1;
            end
            OP_DOT_A: begin
                dot_sel = DOT_A;
                dot_wr  = 1'b1;
            end
            OP_DOT_ONE: begin
                dot_sel = DOT_ONE;
                dot_wr  = 1'b1;
            end
            OP_TEXT: begin
                if (item.flag) begin
                    // append, or shift then append once the line is full
                    if (len_reg < LenW'(LINE_WIDTH)) begin
                        len_next = len_reg + LenW'(1);
                        txt_act  = TXT_APPEND;
                    end else begin
                        txt_act  = TXT_SHIFT;
                    end
                    txt_chr = item.value;
                end else if (len_reg != '0) begin
                    // overwrite last; dropped on an empty line
                    txt_act = TXT_OVERWR;
                    txt_chr = item.value;
                end
            end
            default: begin
            end
        endcase
    end

    // Form the result from the updated state
    always_comb begin
        res.scan_select  = scan_strobe(pos_next);
        res.segment_code = seg_code(dig_next[pos_next]);
        res.led_pattern  = {~led_next, 4'h0};
        res.ascii_digits = {asc_next[3], asc_next[2], asc_next[1], asc_next[0]};
        res.ascii_write  = asc_wr;
        res.dot_choice   = dot_sel;
        res.dot_write    = dot_wr;
        res.text_action  = txt_act;
        res.text_char    = txt_chr;
        res.text_length  = 6'(len_next);
    end

    // Commit the state on each executed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 2'd0;
            led_reg <= 4'h0;
            len_reg <= '0;
            for (int i = 0; i < DigitCount; i++) begin
                dig_reg[i] <= 4'd0;
                asc_reg[i] <= 8'h00;
            end
        end else if (exec_en) begin
            pos_reg <= pos_next;
            led_reg <= led_next;
            len_reg <= len_next;
            dig_reg <= dig_next;
            asc_reg <= asc_next;
        end
    end

endmodule

[sim/display_output_controller_core_tb.sv]
module display_output_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import doc_pkg::*;

    localparam int TextWidth = 32;

    // Shadow of the display state; predicts one frame per accepted command
    class display_mirror;
        bit [7:0]    seg_lut [11] = '{8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49,
                                      8'hC1, 8'h1F, 8'h01, 8'h09, 8'h00};
        bit [7:0]    strobe_lut [4] = '{8'h02, 8'h04, 8'h10, 8'h80};
        bit [1:0]    scan_pos;
        bit [3:0]    digit_val [4];
        bit          led_on [4];
        bit [7:0]    ascii_byte [4];
        int unsigned line_len;
        int unsigned width_limit;
        res_t        pending_frames [$];
        int          commands_noted;
        int          frames_checked;
        int          mismatches;
        int          appends, shift_appends, overwrites, skipped_overwrites, clears;

        function new(int unsigned width);
            width_limit = width;
            scan_pos = 2'd0;
            line_len = 0;
            for (int i = 0; i < 4; i++) begin
                digit_val[i] = 4'd0;
                led_on[i] = 1'b0;
                ascii_byte[i] = 8'd0;
            end
        endfunction

        // Advance the shadow by one tick and form the frame it shows
        function res_t predict_frame(item_t cmd);
            res_t       f;
            logic [7:0] leds;
            f = '0;
            scan_pos = scan_pos + 2'd1;
            case (cmd.opcode)
                OP_CLEAR: begin
                    for (int i = 0; i < 4; i++) begin
                        digit_val[i] = 4'd0;
                        led_on[i] = 1'b0;
                        ascii_byte[i] = 8'd0;
                    end
                    line_len = 0;
                    f.ascii_write = 1'b1;
                    f.dot_write = 1'b1;
                    f.dot_choice = DOT_BLANK;
                    f.text_action = TXT_CLEARED;
                    clears++;
                end
                OP_SCAN_DIG: begin
                    digit_val[cmd.slot] = (cmd.value > 8'd10) ? DigBlank : cmd.value[3:0];
                end
                OP_LED: begin
                    led_on[cmd.slot] = cmd.flag;
                end
                OP_ASCII_DIG: begin
                    ascii_byte[cmd.slot] = cmd.value + AsciiZero;
                    f.ascii_write = 1'b1;
                end
                OP_DOT_A: begin
                    f.dot_choice = DOT_A;
                    f.dot_write = 1'b1;
                end
                OP_DOT_ONE: begin
                    f.dot_choice = DOT_ONE;
                    f.dot_write = 1'b1;
                end
                OP_TEXT: begin
                    if (cmd.flag) begin
                        if (line_len < width_limit) begin
                            line_len++;
                            f.text_action = TXT_APPEND;
                            appends++;
                        end else begin
                            f.text_action = TXT_SHIFT;
                            shift_appends++;
                        end
                        f.text_char = cmd.value;
                    end else if (line_len != 0) begin
                        f.text_action = TXT_OVERWR;
                        f.text_char = cmd.value;
                        overwrites++;
                    end else begin
                        skipped_overwrites++;
                    end
                end
                default: ;
            endcase
            // LEDs are active low on the upper nibble
            leds = 8'hF0;
            for (int i = 0; i < 4; i++)
                if (led_on[i])
                    leds = leds - (8'h10 << i);
            f.scan_select  = strobe_lut[scan_pos];
            f.segment_code = seg_lut[digit_val[scan_pos]];
            f.led_pattern  = leds;
            f.ascii_digits = {ascii_byte[3], ascii_byte[2], ascii_byte[1], ascii_byte[0]};
            f.text_length  = line_len[5:0];
            return f;
        endfunction

        function void note_command(item_t cmd);
            pending_frames.push_back(predict_frame(cmd));
            commands_noted++;
        endfunction

        task report(string field, logic [79:0] want, logic [79:0] got);
            $display("MISMATCH frame %0d %s: expected %0h, got %0h",
                     frames_checked, field, want, got);
            mismatches++;
        endtask

        // Compare one output transfer against the oldest prediction
        task check_frame(logic [79:0] raw);
            res_t got, want;
            got = res_t'(raw[76:0]);
            if (pending_frames.size() == 0) begin
                report("unexpected frame", '0, raw);
                frames_checked++;
                return;
            end
            want = pending_frames.pop_front();
            if (got.scan_select !== want.scan_select)
                report("scan_select", want.scan_select, got.scan_select);
            if (got.segment_code !== want.segment_code)
                report("segment_code", want.segment_code, got.segment_code);
            if (got.led_pattern !== want.led_pattern)
                report("led_pattern", want.led_pattern, got.led_pattern);
            if (got.ascii_digits !== want.ascii_digits)
                report("ascii_digits", want.ascii_digits, got.ascii_digits);
            if (got.ascii_write !== want.ascii_write)
                report("ascii_write", want.ascii_write, got.ascii_write);
            if (got.dot_choice !== want.dot_choice)
                report("dot_choice", want.dot_choice, got.dot_choice);
            if (got.dot_write !== want.dot_write)
                report("dot_write", want.dot_write, got.dot_write);
            if (got.text_action !== want.text_action)
                report("text_action", want.text_action, got.text_action);
            if (got.text_char !== want.text_char)
                report("text_char", want.text_char, got.text_char);
            if (got.text_length !== want.text_length)
                report("text_length", want.text_length, got.text_length);
            if (raw[79:77] !== 3'b000)
                report("pad bits", 3'b000, raw[79:77]);
            frames_checked++;
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // slot[1:0], value[9:2], flag[10], zero[15:11]
    logic [2:0]  s_tuser;    // opcode[2:0]
    logic        m_tvalid;
    logic        m_tready;
    // scan_select[7:0], segment_code[15:8], led_pattern[23:16],
    // ascii_digits[55:24], ascii_write[56], dot_choice[58:57], dot_write[59],
    // text_action[62:60], text_char[70:63], text_length[76:71], zero[79:77]
    logic [79:0] m_tdata;

    display_mirror book = new(TextWidth);
    bit            send_calm;
    int            random_sent;

    display_output_controller_core #(
        .LINE_WIDTH(TextWidth)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Offer one command, optionally after an idle gap, and hold until transfer
    task offer_command(logic [2:0] op, logic [1:0] slot, logic [7:0] value, logic flag);
        int    gap;
        item_t cmd;
        gap = send_calm ? 0 : $urandom_range(0, 7);
        cmd.opcode = op;
        cmd.slot = slot;
        cmd.value = value;
        cmd.flag = flag;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, flag, value, slot};
        s_tuser  <= op;
        do @(posedge aclk); while (s_tready !== 1'b1);
        book.note_command(cmd);
    endtask

    // Random command of any kind; clears are kept rare so the text line can fill
    task offer_mixed();
        logic [2:0] op;
        op = 3'($urandom_range(0, 7));
        if (op == OP_CLEAR && $urandom_range(0, 15) != 0)
            op = OP_NONE;
        offer_command(op, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    // Output side: random stalls, calm stretches, and two long hold-offs
    initial begin
        int stall;
        bit calm;
        calm = 1'b0;
        m_tready <= 1'b0;
        forever begin
            if (book.frames_checked % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 7);
            if (book.frames_checked == 300 || book.frames_checked == 800)
                stall = 150;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            book.check_frame(m_tdata);
        end
    end

    // Run ceiling
    initial begin
        #2_000_000;
        $display("display_output_controller_core regression: fail");
        $finish;
    end

    initial begin
        int burst;
        int kind;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_NONE;
        send_calm = 1'b0;
        random_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: digit limits, LEDs, ASCII wrap, dot patterns, text edge cases
        offer_command(OP_NONE, 2'd0, 8'd0, 1'b0);
        offer_command(OP_SCAN_DIG, 2'd0, 8'd9, 1'b0);
        offer_command(OP_SCAN_DIG, 2'd1, 8'd10, 1'b0);
        offer_command(OP_SCAN_DIG, 2'd2, 8'd11, 1'b1);
        offer_command(OP_SCAN_DIG, 2'd3, 8'd255, 1'b0);
        offer_command(OP_LED, 2'd0, 8'd0, 1'b1);
        offer_command(OP_LED, 2'd1, 8'd0, 1'b1);
        offer_command(OP_LED, 2'd2, 8'd0, 1'b1);
        offer_command(OP_LED, 2'd3, 8'd255, 1'b1);
        offer_command(OP_LED, 2'd2, 8'd0, 1'b0);
        offer_command(OP_ASCII_DIG, 2'd0, 8'd0, 1'b0);
        offer_command(OP_ASCII_DIG, 2'd1, 8'd207, 1'b0);
        offer_command(OP_ASCII_DIG, 2'd2, 8'd208, 1'b0);
        offer_command(OP_ASCII_DIG, 2'd3, 8'd255, 1'b1);
        offer_command(OP_DOT_A, 2'd0, 8'd0, 1'b0);
        offer_command(OP_DOT_ONE, 2'd3, 8'd255, 1'b1);
        offer_command(OP_TEXT, 2'd0, 8'h41, 1'b0);
        offer_command(OP_TEXT, 2'd0, 8'h41, 1'b1);
        offer_command(OP_TEXT, 2'd1, 8'hFF, 1'b1);
        offer_command(OP_TEXT, 2'd2, 8'h42, 1'b0);
        offer_command(OP_CLEAR, 2'd3, 8'd255, 1'b1);
        offer_command(OP_TEXT, 2'd0, 8'h00, 1'b0);
        offer_command(OP_NONE, 2'd3, 8'd255, 1'b1);
        offer_command(OP_SCAN_DIG, 2'd0, 8'd0, 1'b0);

        // Random: text bursts long enough to fill the line, mixed runs, rare clears
        while (random_sent < 1250) begin
            kind = $urandom_range(0, 9);
            send_calm = ($urandom_range(0, 4) == 0);
            if (kind == 0) begin
                offer_command(OP_CLEAR, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                random_sent++;
            end else if (kind <= 4) begin
                burst = $urandom_range(10, 45);
                repeat (burst) begin
                    offer_command(OP_TEXT, 2'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)),
                                  $urandom_range(0, 19) < 17);
                    random_sent++;
                end
            end else begin
                burst = $urandom_range(5, 30);
                repeat (burst) begin
                    offer_mixed();
                    random_sent++;
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding frames, then watch for strays
        while (book.pending_frames.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d commands (%0d random), %0d frames checked, %0d mismatches",
                 book.commands_noted, random_sent, book.frames_checked, book.mismatches);
        $display("text line: %0d appends, %0d shift-appends, %0d overwrites, %0d ignored, %0d clears",
                 book.appends, book.shift_appends, book.overwrites,
                 book.skipped_overwrites, book.clears);
        if (book.mismatches == 0) begin
            $display("display_output_controller_core regression: pass");
        end else begin
            $display("display_output_controller_core regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/doc_pkg.sv
rtl/core/doc_exec.sv
rtl/core/display_output_controller_core.sv
sim/display_output_controller_core_tb.sv
